>>> rtl/rapt_pkg.sv
// shared types and constants for the request/answer pairing table
package rapt_pkg;

    localparam int unsigned KEY_W  = 64;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned APP_W  = 32;
    localparam int unsigned TMO_W  = 16;
    localparam int unsigned CIDX_W = 8;
    localparam int unsigned CDAT_W = 32;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_APP_ID  = 8'd0;
    localparam logic [CIDX_W-1:0] REG_TIMEOUT = 8'd1;

    // reset values of the configuration registers
    localparam logic [APP_W-1:0] APP_ID_RST  = 32'd16777251;
    localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd300;

    // item kinds on the input
    localparam logic FUNC_MSG   = 1'b0;
    localparam logic FUNC_SWEEP = 1'b1;

    // result status codes
    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_PAIRED  = 3'd1,
        ST_FULL    = 3'd2,
        ST_IGNORED = 3'd3,
        ST_EXPIRED = 3'd4,
        ST_NOTHING = 3'd5
    } res_status_t;

    // flush kinds
    localparam logic [1:0] FK_BOTH = 2'd0;
    localparam logic [1:0] FK_REQ  = 2'd1;
    localparam logic [1:0] FK_ANS  = 2'd2;
    localparam logic [1:0] FK_NONE = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_LOOK_CMP,
        S_LOOK_RD,
        S_SWEEP_EVAL,
        S_SEARCH,
        S_RESULT
    } rapt_state_t;

    // controller to datapath
    typedef struct packed {
        logic        cap;
        logic        step_idx;
        logic        set_res;
        res_status_t res_kind;
        logic        pair_hit;
        logic        srch_init;
        logic        srch_step;
        logic        claim;
        logic        expire;
        logic        load_out;
    } rapt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic func;
        logic sweep_ok;
        logic app_match;
        logic hit;
        logic last_idx;
        logic full;
        logic p_free;
        logic expired;
        logic out_free;
    } rapt_stat_t;

endpackage

>>> rtl/rapt_in_if.sv
// input item channel
interface rapt_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic        is_request;
    logic [31:0] app_id;
    logic [63:0] txn_key;
    logic [31:0] now_sec;
    logic [7:0]  sweep_slot;

    modport source (output valid, func, is_request, app_id, txn_key, now_sec, sweep_slot,
                    input ready);
    modport sink (input valid, func, is_request, app_id, txn_key, now_sec, sweep_slot,
                  output ready);
endinterface

>>> rtl/rapt_out_if.sv
// result item channel
interface rapt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  slot;
    logic [63:0] matched_key;
    logic [31:0] request_time;
    logic [31:0] answer_time;
    logic [1:0]  flush_kind;
    logic [8:0]  active_count;

    modport source (output valid, status, slot, matched_key, request_time, answer_time,
                    flush_kind, active_count, input ready);
    modport sink (input valid, status, slot, matched_key, request_time, answer_time,
                  flush_kind, active_count, output ready);
endinterface

>>> rtl/rapt_cfg_if.sv
// configuration write channel
interface rapt_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/rapt_ram.sv
// generic single write port ram with registered read
module rapt_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/rapt_ctrl.sv
// sequencing state machine of the pairing table
module rapt_ctrl
    import rapt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  rapt_stat_t stat,
    output rapt_cmd_t  cmd
);
    rapt_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_kind = ST_NOTHING;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.func == FUNC_SWEEP)
                begin
                    if (stat.sweep_ok)
                    begin
                        state_next = S_SWEEP_EVAL;
                    end
                    else
                    begin
                        cmd.set_res  = 1'b1;
                        cmd.res_kind = ST_NOTHING;
                        state_next   = S_RESULT;
                    end
                end
                else if (!stat.app_match)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_kind = ST_IGNORED;
                    state_next   = S_RESULT;
                end
                else
                begin
                    state_next = S_LOOK_CMP;
                end
            end
            S_LOOK_CMP:
            begin
                if (stat.hit)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_kind = ST_PAIRED;
                    cmd.pair_hit = 1'b1;
                    state_next   = S_RESULT;
                end
                else if (!stat.last_idx)
                begin
                    cmd.step_idx = 1'b1;
                    state_next   = S_LOOK_RD;
                end
                else if (stat.full)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_kind = ST_FULL;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.srch_init = 1'b1;
                    state_next    = S_SEARCH;
                end
            end
            S_LOOK_RD:
            begin
                state_next = S_LOOK_CMP;
            end
            S_SWEEP_EVAL:
            begin
                cmd.set_res = 1'b1;
                if (stat.expired)
                begin
                    cmd.res_kind = ST_EXPIRED;
                    cmd.expire   = 1'b1;
                end
                else
                begin
                    cmd.res_kind = ST_NOTHING;
                end
                state_next = S_RESULT;
            end
            S_SEARCH:
            begin
                if (stat.p_free)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_kind = ST_STORED;
                    cmd.claim    = 1'b1;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.srch_step = 1'b1;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

>>> rtl/rapt_dp.sv
// datapath: item registers, slot table, counters and result registers
module rapt_dp
    import rapt_pkg::*;
#(
    parameter int unsigned POOL_SLOTS = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    rapt_in_if.sink    in_ch,
    rapt_out_if.source out_ch,
    rapt_cfg_if.sink   cfg,
    input  rapt_cmd_t  cmd,
    output rapt_stat_t stat
);
    localparam int unsigned IDXW = $clog2(POOL_SLOTS);
    localparam int unsigned CNTW = IDXW + 1;
    localparam logic [IDXW-1:0] LAST = IDXW'(POOL_SLOTS - 1);

    // configuration
    logic [APP_W-1:0] app_id_reg;
    logic [TMO_W-1:0] tmo_reg;

    // captured item
    logic              func_reg;
    logic              isreq_reg;
    logic [APP_W-1:0]  app_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [TIME_W-1:0] now_reg;
    logic [7:0]        sw_reg;

    // table state
    logic [POOL_SLOTS-1:0] valid_reg;
    logic [IDXW-1:0]       idx_reg;
    logic [IDXW-1:0]       p_reg;
    logic [IDXW-1:0]       ptr_reg;
    logic [CNTW-1:0]       count_reg;

    // pending result
    res_status_t       res_status_reg;
    logic [7:0]        res_slot_reg;
    logic [KEY_W-1:0]  res_key_reg;
    logic [TIME_W-1:0] res_rq_reg;
    logic [TIME_W-1:0] res_an_reg;
    logic [1:0]        res_kind_reg;

    // output register
    logic              out_valid_reg;
    logic [2:0]        out_status_reg;
    logic [7:0]        out_slot_reg;
    logic [KEY_W-1:0]  out_key_reg;
    logic [TIME_W-1:0] out_rq_reg;
    logic [TIME_W-1:0] out_an_reg;
    logic [1:0]        out_kind_reg;
    logic [8:0]        out_count_reg;

    // ram ports
    logic              key_we, rq_we, an_we;
    logic [IDXW-1:0]   waddr;
    logic [TIME_W-1:0] rq_wdata, an_wdata;
    logic [KEY_W-1:0]  key_rdata;
    logic [TIME_W-1:0] rq_rdata, an_rdata;

    logic              rq_old, an_old;
    logic [TIME_W-1:0] rq_age, an_age;
    logic [IDXW-1:0]   p_adv, ptr_adv;
    logic [1:0]        exp_kind;
    logic [TIME_W-1:0] pair_rq, pair_an;

    assign cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            app_id_reg <= APP_ID_RST;
            tmo_reg    <= TIMEOUT_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_APP_ID)
            begin
                app_id_reg <= cfg.data;
            end
            else if (cfg.index == REG_TIMEOUT)
            begin
                tmo_reg <= cfg.data[TMO_W-1:0];
            end
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            func_reg  <= in_ch.func;
            isreq_reg <= in_ch.is_request;
            app_reg   <= in_ch.app_id;
            key_reg   <= in_ch.txn_key;
            now_reg   <= in_ch.now_sec;
            sw_reg    <= in_ch.sweep_slot;
        end
    end

    // wrap-around advance
    assign p_adv   = (p_reg == LAST) ? '0 : p_reg + 1'b1;
    assign ptr_adv = (ptr_reg == LAST) ? '0 : ptr_reg + 1'b1;

    // scan index, search pointer, valid map and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            p_reg     <= '0;
            ptr_reg   <= '0;
            count_reg <= '0;
            valid_reg <= '0;
        end
        else
        begin
            if (cmd.cap)
            begin
                idx_reg <= (in_ch.func == FUNC_SWEEP) ? IDXW'(32'(in_ch.sweep_slot)) : '0;
            end
            else if (cmd.step_idx)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.srch_init)
            begin
                p_reg <= ptr_adv;
            end
            else if (cmd.srch_step)
            begin
                p_reg <= p_adv;
            end
            if (cmd.pair_hit || cmd.expire)
            begin
                valid_reg[idx_reg] <= 1'b0;
                count_reg          <= count_reg - 1'b1;
            end
            else if (cmd.claim)
            begin
                valid_reg[p_reg] <= 1'b1;
                count_reg        <= count_reg + 1'b1;
                ptr_reg          <= p_reg;
            end
        end
    end

    // table writes
    always_comb
    begin
        key_we   = cmd.claim;
        rq_we    = cmd.claim || (cmd.pair_hit && isreq_reg);
        an_we    = cmd.claim || (cmd.pair_hit && !isreq_reg);
        waddr    = cmd.claim ? p_reg : idx_reg;
        rq_wdata = (cmd.claim && !isreq_reg) ? '0 : now_reg;
        an_wdata = (cmd.claim && isreq_reg) ? '0 : now_reg;
    end

    rapt_ram #(.WIDTH(KEY_W), .DEPTH(POOL_SLOTS)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (waddr),
        .wdata (key_reg),
        .raddr (idx_reg),
        .rdata (key_rdata)
    );

    rapt_ram #(.WIDTH(TIME_W), .DEPTH(POOL_SLOTS)) u_rq_ram (
        .clk   (clk),
        .we    (rq_we),
        .waddr (waddr),
        .wdata (rq_wdata),
        .raddr (idx_reg),
        .rdata (rq_rdata)
    );

    rapt_ram #(.WIDTH(TIME_W), .DEPTH(POOL_SLOTS)) u_an_ram (
        .clk   (clk),
        .we    (an_we),
        .waddr (waddr),
        .wdata (an_wdata),
        .raddr (idx_reg),
        .rdata (an_rdata)
    );

    // expiry check
    assign rq_age   = now_reg - rq_rdata;
    assign an_age   = now_reg - an_rdata;
    assign rq_old   = (rq_rdata != '0) && (rq_age > TIME_W'(tmo_reg));
    assign an_old   = (an_rdata != '0) && (an_age > TIME_W'(tmo_reg));
    assign exp_kind = (rq_rdata == '0 && an_rdata != '0) ? FK_ANS :
                      (an_rdata == '0 && rq_rdata != '0) ? FK_REQ : FK_BOTH;
    assign pair_rq  = isreq_reg ? now_reg : rq_rdata;
    assign pair_an  = isreq_reg ? an_rdata : now_reg;

    // status to controller
    always_comb
    begin
        stat.func      = func_reg;
        stat.sweep_ok  = (32'(sw_reg) < 32'(POOL_SLOTS)) && valid_reg[idx_reg];
        stat.app_match = (app_reg == app_id_reg);
        stat.hit       = valid_reg[idx_reg] && (key_rdata == key_reg);
        stat.last_idx  = (idx_reg == LAST);
        stat.full      = (32'(count_reg) >= 32'(POOL_SLOTS));
        stat.p_free    = !valid_reg[p_reg];
        stat.expired   = rq_old || an_old;
        stat.out_free  = !out_valid_reg || out_ch.ready;
    end

    // pending result
    always_ff @(posedge clk)
    begin
        if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_kind;
            case (cmd.res_kind)
                ST_STORED:
                begin
                    res_slot_reg <= 8'(p_reg);
                    res_key_reg  <= key_reg;
                    res_rq_reg   <= isreq_reg ? now_reg : '0;
                    res_an_reg   <= isreq_reg ? '0 : now_reg;
                    res_kind_reg <= FK_NONE;
                end
                ST_PAIRED:
                begin
                    res_slot_reg <= 8'(idx_reg);
                    res_key_reg  <= key_reg;
                    res_rq_reg   <= pair_rq;
                    res_an_reg   <= pair_an;
                    res_kind_reg <= FK_BOTH;
                end
                ST_FULL:
                begin
                    res_slot_reg <= '0;
                    res_key_reg  <= key_reg;
                    res_rq_reg   <= '0;
                    res_an_reg   <= '0;
                    res_kind_reg <= FK_NONE;
                end
                ST_EXPIRED:
                begin
                    res_slot_reg <= sw_reg;
                    res_key_reg  <= key_rdata;
                    res_rq_reg   <= rq_rdata;
                    res_an_reg   <= an_rdata;
                    res_kind_reg <= exp_kind;
                end
                ST_NOTHING:
                begin
                    res_slot_reg <= sw_reg;
                    res_key_reg  <= '0;
                    res_rq_reg   <= '0;
                    res_an_reg   <= '0;
                    res_kind_reg <= FK_NONE;
                end
                default:
                begin
                    res_slot_reg <= '0;
                    res_key_reg  <= '0;
                    res_rq_reg   <= '0;
                    res_an_reg   <= '0;
                    res_kind_reg <= FK_NONE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_key_reg    <= res_key_reg;
            out_rq_reg     <= res_rq_reg;
            out_an_reg     <= res_an_reg;
            out_kind_reg   <= res_kind_reg;
            out_count_reg  <= 9'(count_reg);
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = out_status_reg;
    assign out_ch.slot         = out_slot_reg;
    assign out_ch.matched_key  = out_key_reg;
    assign out_ch.request_time = out_rq_reg;
    assign out_ch.answer_time  = out_an_reg;
    assign out_ch.flush_kind   = out_kind_reg;
    assign out_ch.active_count = out_count_reg;
endmodule

>>> rtl/request_answer_pairing_table.sv
// Request/answer pairing table, top level.
// Steps: an ignored message or a sweep of a free slot goes straight to the result; any other
// sweep checks its slot for expiry; a message reads the slots from 0 until its key hits; with
// no hit it is dropped if full, else stored in the first free slot after the last claimed slot.
// Throughput: one item at a time, the next is taken once the result is loaded.
// Reset: asynchronous active low; clears valid map, counters and pointer, loads config defaults.
module request_answer_pairing_table
    import rapt_pkg::*;
#(
    parameter int unsigned POOL_SLOTS = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    rapt_in_if.sink    in_ch,
    rapt_out_if.source out_ch,
    rapt_cfg_if.sink   cfg
);
    rapt_cmd_t  cmd;
    rapt_stat_t stat;
    logic       ready;

    rapt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rapt_dp #(.POOL_SLOTS(POOL_SLOTS)) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg),
        .cmd    (cmd),
        .stat   (stat)
    );

    assign in_ch.ready = ready;
endmodule

>>> tb/sv/request_answer_pairing_table_test.sv
// testbench for the request/answer pairing table: directed table plus random traffic
`timescale 1ns / 100ps

module request_answer_pairing_table_test;
    import rapt_pkg::*;

    localparam int unsigned SLOTS = 256;
    localparam int unsigned WATCH_LIMIT = 200000;

    // one stimulus item
    typedef struct {
        logic        func;
        logic        is_req;
        logic [31:0] app;
        logic [63:0] key;
        logic [31:0] now;
        logic [7:0]  sw;
    } msg_item_t;

    // one result item
    typedef struct {
        res_status_t status;
        logic [7:0]  slot;
        logic [63:0] key;
        logic [31:0] rq;
        logic [31:0] an;
        logic [1:0]  kind;
        logic [8:0]  active;
    } pair_result_t;

    // directed row: item plus optional typed-in result
    typedef struct {
        msg_item_t    item;
        logic         typed;
        pair_result_t res;
    } dir_row_t;

    logic clk;
    logic rst_n;
    rapt_in_if  in_ch ();
    rapt_out_if out_ch ();
    rapt_cfg_if cfg ();

    request_answer_pairing_table dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // predictor state
    logic [31:0] app_id_cfg;
    logic [15:0] timeout_cfg;
    logic        tbl_valid [SLOTS];
    logic [63:0] tbl_key [SLOTS];
    logic [31:0] tbl_rq [SLOTS];
    logic [31:0] tbl_an [SLOTS];
    int unsigned fit_ptr;
    int unsigned occupied;

    pair_result_t pending_results[$];
    logic [63:0]  live_keys[$];
    int unsigned  errors;
    int unsigned  idle_cycles;

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic pair_result_t mk_res(res_status_t st, logic [7:0] s, logic [63:0] k,
                                            logic [31:0] rq, logic [31:0] an,
                                            logic [1:0] kd, int unsigned act);
        pair_result_t r;
        r.status = st;
        r.slot = s;
        r.key = k;
        r.rq = rq;
        r.an = an;
        r.kind = kd;
        r.active = act[8:0];
        return r;
    endfunction

    // compute the expected result and update the table copy
    function automatic pair_result_t pair_predict(msg_item_t it);
        int unsigned p;
        int unsigned n;
        logic        old_rq;
        logic        old_an;
        logic [1:0]  kd;
        logic [31:0] rq;
        logic [31:0] an;
        if (it.func == FUNC_SWEEP)
        begin
            if (!tbl_valid[it.sw])
                return mk_res(ST_NOTHING, it.sw, '0, '0, '0, FK_NONE, occupied);
            rq = tbl_rq[it.sw];
            an = tbl_an[it.sw];
            old_rq = (rq != 0) && ((it.now - rq) > {16'd0, timeout_cfg});
            old_an = (an != 0) && ((it.now - an) > {16'd0, timeout_cfg});
            if (!old_rq && !old_an)
                return mk_res(ST_NOTHING, it.sw, '0, '0, '0, FK_NONE, occupied);
            if (rq == 0 && an != 0)
                kd = FK_ANS;
            else if (an == 0 && rq != 0)
                kd = FK_REQ;
            else
                kd = FK_BOTH;
            tbl_valid[it.sw] = 1'b0;
            occupied--;
            return mk_res(ST_EXPIRED, it.sw, tbl_key[it.sw], rq, an, kd, occupied);
        end
        if (it.app != app_id_cfg)
            return mk_res(ST_IGNORED, '0, '0, '0, '0, FK_NONE, occupied);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (tbl_valid[i] && tbl_key[i] == it.key)
            begin
                if (it.is_req)
                    tbl_rq[i] = it.now;
                else
                    tbl_an[i] = it.now;
                tbl_valid[i] = 1'b0;
                occupied--;
                return mk_res(ST_PAIRED, i[7:0], it.key, tbl_rq[i], tbl_an[i], FK_BOTH,
                              occupied);
            end
        end
        if (occupied >= SLOTS)
            return mk_res(ST_FULL, '0, it.key, '0, '0, FK_NONE, occupied);
        p = (fit_ptr + 1) % SLOTS;
        for (n = 0; n < SLOTS && tbl_valid[p]; n++)
            p = (p + 1) % SLOTS;
        fit_ptr = p;
        tbl_valid[p] = 1'b1;
        tbl_key[p] = it.key;
        tbl_rq[p] = it.is_req ? it.now : 32'd0;
        tbl_an[p] = it.is_req ? 32'd0 : it.now;
        occupied++;
        return mk_res(ST_STORED, p[7:0], it.key, tbl_rq[p], tbl_an[p], FK_NONE, occupied);
    endfunction

    // result checker with random stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        pair_result_t e;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with none expected, status %0d", $time, out_ch.status);
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (out_ch.status !== e.status || out_ch.slot !== e.slot
                        || out_ch.matched_key !== e.key || out_ch.request_time !== e.rq
                        || out_ch.answer_time !== e.an || out_ch.flush_kind !== e.kind
                        || out_ch.active_count !== e.active)
                    begin
                        errors++;
                        $display({"%0t: mismatch expected st %0d slot %0d key %h rq %0d",
                                  " an %0d fk %0d act %0d"},
                                 $time, e.status, e.slot, e.key, e.rq, e.an, e.kind, e.active);
                        $display({"%0t:          actual st %0d slot %0d key %h rq %0d",
                                  " an %0d fk %0d act %0d"},
                                 $time, out_ch.status, out_ch.slot, out_ch.matched_key,
                                 out_ch.request_time, out_ch.answer_time, out_ch.flush_kind,
                                 out_ch.active_count);
                    end
                end
            end
            // stall pattern: choppy stretches alternating with clean ones of equal length
            if ((($time / 12) / 3000) % 2 == 1)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // watchdog on accepted handshakes
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("request_answer_pairing_table_test: errors");
            $finish;
        end
    end

    // drive one item, with the typed result if any
    task automatic send_item(msg_item_t it, logic typed, pair_result_t want);
        pair_result_t p;
        in_ch.valid      <= 1'b1;
        in_ch.func       <= it.func;
        in_ch.is_request <= it.is_req;
        in_ch.app_id     <= it.app;
        in_ch.txn_key    <= it.key;
        in_ch.now_sec    <= it.now;
        in_ch.sweep_slot <= it.sw;
        do
            @(posedge clk);
        while (!in_ch.ready);
        p = pair_predict(it);
        pending_results.push_back(typed ? want : p);
        if (it.func == FUNC_MSG && p.status == ST_STORED)
            live_keys.push_back(it.key);
    endtask

    task automatic idle_input();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait for all results, then let the block settle
    task automatic drain();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * SLOTS + 2 * SLOTS + 20)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge clk);
        if (idx == REG_APP_ID)
            app_id_cfg = val;
        else
            timeout_cfg = val[15:0];
    endtask

    function automatic msg_item_t mk_msg(logic req, logic [31:0] app, logic [63:0] k,
                                         logic [31:0] t);
        msg_item_t it;
        it.func = FUNC_MSG;
        it.is_req = req;
        it.app = app;
        it.key = k;
        it.now = t;
        it.sw = 8'($urandom);
        return it;
    endfunction

    function automatic msg_item_t mk_sweep(logic [7:0] s, logic [31:0] t);
        msg_item_t it;
        it = mk_msg(1'($urandom_range(0, 1)), $urandom, {$urandom, $urandom}, t);
        it.func = FUNC_SWEEP;
        it.sw = s;
        return it;
    endfunction

    // random item: mostly well-formed pair traffic from a small key set
    function automatic msg_item_t rand_item(logic [31:0] t);
        int unsigned r;
        logic [63:0] k;
        r = $urandom_range(0, 99);
        if (r < 25)
            return mk_sweep(r < 20 ? 8'($urandom_range(0, 40)) : 8'($urandom), t);
        if (r < 30)
            return mk_msg(1'($urandom_range(0, 1)), $urandom, {$urandom, $urandom}, t);
        if (r < 60 && live_keys.size() != 0)
            k = live_keys[$urandom_range(0, live_keys.size() - 1)];
        else if (r < 70)
            k = {$urandom, $urandom};
        else
            k = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0, 32'($urandom_range(0, 63))};
        return mk_msg(1'($urandom_range(0, 1)), app_id_cfg, k, t);
    endfunction

    initial
    begin
        dir_row_t     rows[$];
        dir_row_t     row;
        msg_item_t    it;
        logic [31:0]  clock_sec;
        int unsigned  burst;
        pair_result_t no_res;

        errors = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.func = 1'b0;
        in_ch.is_request = 1'b0;
        in_ch.app_id = '0;
        in_ch.txn_key = '0;
        in_ch.now_sec = '0;
        in_ch.sweep_slot = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        app_id_cfg = APP_ID_RST;
        timeout_cfg = TIMEOUT_RST;
        fit_ptr = 0;
        occupied = 0;
        no_res = mk_res(ST_NOTHING, '0, '0, '0, '0, FK_NONE, 0);
        for (int i = 0; i < SLOTS; i++)
            tbl_valid[i] = 1'b0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table under reset configuration
        row.typed = 1'b1;
        row.item = mk_sweep(8'd0, 32'hFFFF_FFFF);
        row.res = mk_res(ST_NOTHING, 8'd0, '0, '0, '0, FK_NONE, 0);
        rows.push_back(row);
        row.item = mk_sweep(8'd255, 32'd0);
        row.res = mk_res(ST_NOTHING, 8'd255, '0, '0, '0, FK_NONE, 0);
        rows.push_back(row);
        row.item = mk_msg(1'b1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd5);
        row.res = mk_res(ST_IGNORED, '0, '0, '0, '0, FK_NONE, 0);
        rows.push_back(row);
        row.item = mk_msg(1'b1, APP_ID_RST, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1000);
        row.res = mk_res(ST_STORED, 8'd1, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1000, '0, FK_NONE, 1);
        rows.push_back(row);
        row.item = mk_msg(1'b0, APP_ID_RST, 64'd0, 32'hFFFF_FFFF);
        row.res = mk_res(ST_STORED, 8'd2, 64'd0, '0, 32'hFFFF_FFFF, FK_NONE, 2);
        rows.push_back(row);
        row.item = mk_msg(1'b0, APP_ID_RST, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1002);
        row.res = mk_res(ST_PAIRED, 8'd1, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1000, 32'd1002,
                         FK_BOTH, 1);
        rows.push_back(row);
        row.typed = 1'b0;
        // request hitting request, zero time entry, expiries
        row.item = mk_msg(1'b1, APP_ID_RST, 64'h55, 32'd10);
        rows.push_back(row);
        row.item = mk_msg(1'b1, APP_ID_RST, 64'h55, 32'd11);
        rows.push_back(row);
        row.item = mk_msg(1'b1, APP_ID_RST, 64'hAA, 32'd0);
        rows.push_back(row);
        row.item = mk_sweep(8'd4, 32'hFFFF_FFFF);
        rows.push_back(row);
        row.item = mk_msg(1'b1, APP_ID_RST, 64'h77, 32'd100);
        rows.push_back(row);
        row.item = mk_sweep(8'd5, 32'd400);
        rows.push_back(row);
        row.item = mk_sweep(8'd5, 32'd401);
        rows.push_back(row);
        row.item = mk_sweep(8'd2, 32'd299);
        rows.push_back(row);
        row.item = mk_sweep(8'd2, 32'd12);
        rows.push_back(row);
        row.item = mk_msg(1'b0, APP_ID_RST, 64'hAA, 32'd7);
        rows.push_back(row);
        foreach (rows[i])
            send_item(rows[i].item, rows[i].typed, rows[i].res);
        idle_input();
        drain();

        // fill the table to force drops, with both register extremes
        write_reg(REG_APP_ID, 32'hFFFF_FFFF);
        write_reg(REG_TIMEOUT, 32'd0);
        for (int i = 0; i < SLOTS + 4; i++)
            send_item(mk_msg(1'b0, 32'hFFFF_FFFF, {32'hC0DE, 32'(i)}, 32'd50), 1'b0, no_res);
        for (int i = 0; i < SLOTS; i++)
            send_item(mk_sweep(8'(i), 32'd51), 1'b0, no_res);
        idle_input();
        drain();
        live_keys.delete();

        // random phases under several settings
        clock_sec = 32'd1;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_APP_ID, 32'd0);
                    write_reg(REG_TIMEOUT, 32'hFFFF);
                end
                1:
                begin
                    write_reg(REG_APP_ID, 32'h1234_5678);
                    write_reg(REG_TIMEOUT, 32'd20);
                end
                2:
                begin
                    write_reg(REG_APP_ID, APP_ID_RST);
                    write_reg(REG_TIMEOUT, 32'd3);
                end
                default:
                begin
                    write_reg(REG_APP_ID, 32'hFFFF_FFFF);
                    write_reg(REG_TIMEOUT, 32'd1);
                end
            endcase
            for (int n = 0; n < 355; n++)
            begin
                if (ph == 3)
                    clock_sec = $urandom;
                else
                    clock_sec = clock_sec + $urandom_range(0, 2);
                it = rand_item(clock_sec);
                send_item(it, 1'b0, no_res);
                burst = $urandom_range(0, 7);
                if (burst == 0)
                    repeat ($urandom_range(1, 6))
                        idle_input();
                if (n == 200)
                begin
                    // hold off until the block has caught up
                    idle_input();
                    while (pending_results.size() != 0)
                        @(posedge clk);
                end
            end
            idle_input();
            drain();
            live_keys.delete();
        end

        if (errors == 0)
            $display("request_answer_pairing_table_test: clean");
        else
            $display("request_answer_pairing_table_test: errors");
        $finish;
    end

endmodule

>>> request_answer_pairing_table.f
rtl/rapt_pkg.sv
rtl/rapt_in_if.sv
rtl/rapt_out_if.sv
rtl/rapt_cfg_if.sv
rtl/rapt_ram.sv
rtl/rapt_ctrl.sv
rtl/rapt_dp.sv
rtl/request_answer_pairing_table.sv
tb/sv/request_answer_pairing_table_test.sv
